[src/pbst_pkg.sv]
package pbst_pkg;

	localparam int unsigned POOL_NODES_DEF = 1024;
	localparam int unsigned KEY_BITS_DEF   = 64;

	// Operation codes.
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_FIND   = 2'd1;
	localparam logic [1:0] OP_REMOVE = 2'd2;
	localparam logic [1:0] OP_NOP    = 2'd3;

	// Status codes.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_DUP      = 3'd1;
	localparam logic [2:0] ST_FULL     = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_INACTIVE = 3'd4;

	typedef enum logic [4:0] {
		S_IDLE,
		S_CLR,
		S_WALK_RD,
		S_WALK_CMP,
		S_ALLOC_RD,
		S_ALLOC_WR,
		S_LINK_PAR,
		S_RM_RD,
		S_RM_SUCC_RD,
		S_RM_SUCC_CHK,
		S_RM_HANG,
		S_RM_REP,
		S_RM_PRD,
		S_RM_PCHK,
		S_RM_FREE,
		S_OUT
	} state_t;

endpackage

[src/pbst_if.sv]
interface pbst_in_if #(parameter int unsigned KEY_W = 64) (input logic clk);
	logic             valid;
	logic             ready;
	logic [1:0]       op;
	logic [KEY_W-1:0] key;
	logic [9:0]       target_node;
	modport source (output valid, op, key, target_node, input ready);
	modport sink (input valid, op, key, target_node, output ready);
endinterface

interface pbst_out_if (input logic clk);
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic        found;
	logic [9:0]  node_index;
	logic        parent_valid;
	logic [9:0]  parent_index;
	logic [9:0]  depth;
	logic [10:0] active_count;
	modport source (output valid, status, found, node_index, parent_valid, parent_index,
		depth, active_count, input ready);
	modport sink (input valid, status, found, node_index, parent_valid, parent_index,
		depth, active_count, output ready);
endinterface

[src/pbst_ram.sv]
module pbst_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[src/pooled_binary_search_tree_top.sv]
// Each item is taken in S_IDLE, and its result is held in S_OUT until the result side is ready.
// Insert and find read and compare one node per step of the walk; remove reads the target,
// then relinks its child or, with two children, walks leftward to the in-order successor.
// Throughput: one item at a time through a single node memory; a new item is taken only
// after the result of the last one has been taken, and walk depth sets the rate.
// Reset: arst_n clears control state, then the node memory is cleared in S_CLR.
module pooled_binary_search_tree_top import pbst_pkg::*; #(
	parameter int unsigned POOL_NODES = POOL_NODES_DEF,
	parameter int unsigned KEY_BITS   = KEY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,
	pbst_in_if.sink     in_ch,
	pbst_out_if.source  out_ch
);
	localparam int unsigned AW = $clog2(POOL_NODES);
	localparam int unsigned LW = AW + 1;
	localparam int unsigned NW = LW + LW + LW + KEY_BITS + 1;
	localparam logic [LW-1:0] NIL = LW'(POOL_NODES);

	// Node word: active, key, left, right, parent.
	typedef struct packed {
		logic                act;
		logic [KEY_BITS-1:0] key;
		logic [LW-1:0]       lft;
		logic [LW-1:0]       rgt;
		logic [LW-1:0]       par;
	} node_t;

	state_t state_q, state_d;

	logic [10:0]         cap_q;
	logic [LW-1:0]       root_q, root_d, free_q, free_d, fresh_q, fresh_d;
	logic [LW-1:0]       count_q, count_d;
	logic [1:0]          op_q, op_d;
	logic [KEY_BITS-1:0] key_q, key_d;
	logic [LW-1:0]       cur_q, cur_d, par_q, par_d, nn_q, nn_d;
	logic [9:0]          dep_q, dep_d;
	logic [LW-1:0]       tl_q, tl_d, tr_q, tr_d, tp_q, tp_d, rep_q, rep_d;
	node_t               pn_q, pn_d;
	logic [2:0]          st_q, st_d;
	logic                fnd_q, fnd_d;
	logic [LW-1:0]       clr_q, clr_d;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	node_t         wdata, rdata;
	logic [NW-1:0] rbits;

	pbst_ram #(.WIDTH(NW), .DEPTH(POOL_NODES)) u_nodes (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rbits)
	);
	assign rdata = node_t'(rbits);

	logic [LW-1:0] cap_eff;
	assign cap_eff = (cap_q > 11'(POOL_NODES)) ? NIL : LW'(cap_q);

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= 11'd1024;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// Control and working registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			root_q  <= NIL;
			free_q  <= NIL;
			fresh_q <= '0;
			count_q <= '0;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			root_q  <= root_d;
			free_q  <= free_d;
			fresh_q <= fresh_d;
			count_q <= count_d;
			clr_q   <= clr_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q  <= op_d;
		key_q <= key_d;
		cur_q <= cur_d;
		par_q <= par_d;
		nn_q  <= nn_d;
		dep_q <= dep_d;
		tl_q  <= tl_d;
		tr_q  <= tr_d;
		tp_q  <= tp_d;
		rep_q <= rep_d;
		pn_q  <= pn_d;
		st_q  <= st_d;
		fnd_q <= fnd_d;
	end

	// Sequencer: every node access goes through the single node memory.
	always_comb begin
		state_d = state_q;
		root_d = root_q; free_d = free_q; fresh_d = fresh_q; count_d = count_q;
		op_d = op_q; key_d = key_q; cur_d = cur_q; par_d = par_q; nn_d = nn_q;
		dep_d = dep_q; tl_d = tl_q; tr_d = tr_q; tp_d = tp_q; rep_d = rep_q;
		pn_d = pn_q; st_d = st_q; fnd_d = fnd_q; clr_d = clr_q;
		we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
		in_ch.ready = 1'b0;
		out_ch.valid = 1'b0;
		unique case (state_q)
			S_CLR: begin
				we = 1'b1;
				waddr = clr_q[AW-1:0];
				clr_d = clr_q + 1'b1;
				if (clr_q == NIL - 1'b1) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					op_d = in_ch.op;
					key_d = in_ch.key[KEY_BITS-1:0];
					cur_d = root_q;
					par_d = NIL;
					dep_d = '0;
					st_d = ST_OK;
					fnd_d = 1'b0;
					nn_d = NIL;
					rep_d = NIL;
					if (in_ch.op == OP_INSERT || in_ch.op == OP_FIND) begin
						state_d = S_WALK_RD;
					end else if (in_ch.op == OP_REMOVE) begin
						cur_d = LW'(in_ch.target_node);
						if (LW'(in_ch.target_node) >= NIL) begin
							st_d = ST_INACTIVE;
							state_d = S_OUT;
						end else begin
							state_d = S_RM_RD;
						end
					end else begin
						state_d = S_OUT;
					end
				end
			end
			S_WALK_RD: begin
				raddr = cur_q[AW-1:0];
				if (cur_q >= NIL) begin
					if (op_q == OP_FIND) begin
						st_d = ST_NOTFOUND;
						state_d = S_OUT;
					end else begin
						state_d = S_ALLOC_RD;
					end
				end else begin
					state_d = S_WALK_CMP;
				end
			end
			S_WALK_CMP: begin
				if (key_q == rdata.key) begin
					if (op_q == OP_FIND) begin
						fnd_d = 1'b1;
						nn_d = cur_q;
					end else begin
						st_d = ST_DUP;
					end
					state_d = S_OUT;
				end else begin
					par_d = cur_q;
					pn_d = rdata;
					cur_d = (key_q < rdata.key) ? rdata.lft : rdata.rgt;
					dep_d = dep_q + 1'b1;
					state_d = S_WALK_RD;
				end
			end
			S_ALLOC_RD: begin
				// Read the free list head to learn its successor.
				raddr = free_q[AW-1:0];
				if (free_q < NIL) begin
					nn_d = free_q;
					state_d = S_ALLOC_WR;
				end else if (fresh_q >= cap_eff) begin
					st_d = ST_FULL;
					state_d = S_OUT;
				end else begin
					nn_d = fresh_q;
					fresh_d = fresh_q + 1'b1;
					state_d = S_ALLOC_WR;
				end
			end
			S_ALLOC_WR: begin
				if (nn_q == free_q) begin
					free_d = rdata.lft;
				end
				we = 1'b1;
				waddr = nn_q[AW-1:0];
				wdata = '{act: 1'b1, key: key_q, lft: NIL, rgt: NIL, par: par_q};
				count_d = count_q + 1'b1;
				if (par_q >= NIL) begin
					root_d = nn_q;
					state_d = S_OUT;
				end else begin
					state_d = S_LINK_PAR;
				end
			end
			S_LINK_PAR: begin
				we = 1'b1;
				waddr = par_q[AW-1:0];
				wdata = pn_q;
				if (key_q < pn_q.key) begin
					wdata.lft = nn_q;
				end else begin
					wdata.rgt = nn_q;
				end
				state_d = S_OUT;
			end
			S_RM_RD: begin
				raddr = cur_q[AW-1:0];
				state_d = S_RM_SUCC_RD;
				tp_d = NIL;
			end
			S_RM_SUCC_RD: begin
				// First visit captures the target; later visits walk leftward.
				if (tp_q == NIL && rep_q != cur_q) begin
					if (!rdata.act) begin
						st_d = ST_INACTIVE;
						state_d = S_OUT;
					end else begin
						tl_d = rdata.lft;
						tr_d = rdata.rgt;
						tp_d = rdata.par;
						rep_d = cur_q;
						pn_d = rdata;
						if (rdata.lft >= NIL) begin
							nn_d = rdata.rgt;
							state_d = S_RM_REP;
						end else if (rdata.rgt >= NIL) begin
							nn_d = rdata.lft;
							state_d = S_RM_REP;
						end else begin
							nn_d = rdata.rgt;
							par_d = rdata.rgt;
							raddr = rdata.rgt[AW-1:0];
							state_d = S_RM_SUCC_CHK;
						end
					end
				end else begin
					state_d = S_RM_SUCC_CHK;
				end
			end
			S_RM_SUCC_CHK: begin
				if (rdata.lft < NIL) begin
					par_d = rdata.lft;
					raddr = rdata.lft[AW-1:0];
				end else begin
					pn_d = rdata;
					state_d = S_RM_HANG;
				end
			end
			S_RM_HANG: begin
				// Successor gets the left subtree; then fix the subtree's parent.
				if (dep_q == '0) begin
					we = 1'b1;
					waddr = par_q[AW-1:0];
					wdata = pn_q;
					wdata.lft = tl_q;
					dep_d = 10'd1;
					raddr = tl_q[AW-1:0];
				end else if (dep_q == 10'd1) begin
					raddr = tl_q[AW-1:0];
					dep_d = 10'd2;
				end else begin
					we = 1'b1;
					waddr = tl_q[AW-1:0];
					wdata = rdata;
					wdata.par = par_q;
					dep_d = '0;
					state_d = S_RM_REP;
				end
			end
			S_RM_REP: begin
				// Replacement's parent link, read then write.
				if (nn_q >= NIL) begin
					dep_d = '0;
					state_d = S_RM_PRD;
				end else if (dep_q == '0) begin
					raddr = nn_q[AW-1:0];
					dep_d = 10'd1;
				end else if (dep_q == 10'd1) begin
					raddr = nn_q[AW-1:0];
					dep_d = 10'd2;
				end else begin
					we = 1'b1;
					waddr = nn_q[AW-1:0];
					wdata = rdata;
					wdata.par = tp_q;
					dep_d = '0;
					state_d = S_RM_PRD;
				end
			end
			S_RM_PRD: begin
				if (tp_q >= NIL) begin
					root_d = nn_q;
					state_d = S_RM_FREE;
				end else begin
					raddr = tp_q[AW-1:0];
					state_d = S_RM_PCHK;
				end
			end
			S_RM_PCHK: begin
				we = 1'b1;
				waddr = tp_q[AW-1:0];
				wdata = rdata;
				if (rdata.lft == rep_q) begin
					wdata.lft = nn_q;
				end else if (rdata.rgt == rep_q) begin
					wdata.rgt = nn_q;
				end
				state_d = S_RM_FREE;
			end
			S_RM_FREE: begin
				we = 1'b1;
				waddr = rep_q[AW-1:0];
				wdata = pn_q;
				wdata.act = 1'b0;
				wdata.lft = free_q;
				free_d = rep_q;
				if (count_q != '0) begin
					count_d = count_q - 1'b1;
				end
				state_d = S_OUT;
			end
			S_OUT: begin
				out_ch.valid = 1'b1;
				if (out_ch.ready) begin
					rep_d = NIL;
					dep_d = '0;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Result fields; unused fields read as zero.
	always_comb begin
		out_ch.status = st_q;
		out_ch.found = fnd_q;
		out_ch.node_index = '0;
		out_ch.parent_valid = 1'b0;
		out_ch.parent_index = '0;
		out_ch.depth = '0;
		out_ch.active_count = 11'(count_q);
		if (op_q == OP_FIND && fnd_q) begin
			out_ch.node_index = 10'(nn_q);
			out_ch.parent_valid = (par_q < NIL);
			out_ch.parent_index = (par_q < NIL) ? 10'(par_q) : '0;
			out_ch.depth = dep_q;
		end else if (op_q == OP_INSERT && st_q == ST_OK) begin
			out_ch.node_index = 10'(nn_q);
		end
	end

	ap_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= NIL)
		else $error("node count beyond pool");
	ap_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ch.ready && out_ch.valid))
		else $error("ready while result pending");
	ap_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		fresh_q <= NIL)
		else $error("fresh pointer beyond pool");
	ap_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && st_q == ST_FULL) |-> (free_q >= NIL))
		else $error("full reported with free list nonempty");
endmodule
